FILE: hdl/imuca_pkg.sv
package imuca_pkg;

    localparam int ANGLE_LIMIT = 92160;
    localparam int ATAN_ENTRIES = 24;
    localparam int ZW = 32;
    localparam int XW = 40;
    // ceil(2^43 / 15625), exact for dividends below 2^29
    localparam logic [29:0] GYRO_RECIP = 30'd562949954;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [15:0]        elapsed_us;
    } sample_t;

    typedef struct packed {
        logic signed [17:0] roll_angle;
        logic signed [17:0] pitch_angle;
        logic signed [15:0] z_rate;
    } angles_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG,
        ST_SQRT,
        ST_RINIT,
        ST_RITER,
        ST_PINIT,
        ST_PITER,
        ST_GYRO_MUL,
        ST_GYRO_DIV,
        ST_GYRO_ADD,
        ST_BLEND_MUL,
        ST_BLEND_ADD,
        ST_OUT
    } exec_state_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        begin
            unique case (i)
                5'd0: v = 32'sd2949120;
                5'd1: v = 32'sd1740967;
                5'd2: v = 32'sd919879;
                5'd3: v = 32'sd466945;
                5'd4: v = 32'sd234379;
                5'd5: v = 32'sd117304;
                5'd6: v = 32'sd58666;
                5'd7: v = 32'sd29335;
                5'd8: v = 32'sd14668;
                5'd9: v = 32'sd7334;
                5'd10: v = 32'sd3667;
                5'd11: v = 32'sd1833;
                5'd12: v = 32'sd917;
                5'd13: v = 32'sd458;
                5'd14: v = 32'sd229;
                5'd15: v = 32'sd115;
                5'd16: v = 32'sd57;
                5'd17: v = 32'sd29;
                5'd18: v = 32'sd14;
                5'd19: v = 32'sd7;
                5'd20: v = 32'sd4;
                5'd21: v = 32'sd2;
                5'd22: v = 32'sd1;
                default: v = 32'sd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [17:0] clamp_angle(input logic signed [47:0] v);
        begin
            if (v > 48'sd92160)
                return 18'sd92160;
            else if (v < -48'sd92160)
                return -18'sd92160;
            else
                return v[17:0];
        end
    endfunction

endpackage

FILE: hdl/imuca_stream_if.sv
interface imuca_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/imu_complementary_attitude.sv
// channel  | dir | handshake          | payload
// in_ch    | in  | valid/ready        | sample_t (accel xyz, rate xyz, elapsed_us)
// cfg_ch   | in  | valid/ready        | blend_weight, 16 bit
// out_ch   | out | valid/ready        | angles_t (roll, pitch, z_rate)
// one word passes from queue to result register through the bit-serial square root
// and the two passes of the shared cordic stage
// two-word input queue keeps taking words while the sequencer works
// rst_n clears estimates, weight to 64225, queue and result valid
// a stalled result holds; the sequencer goes on and only waits at its next output step
module imu_complementary_attitude
    import imuca_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    imuca_stream_if.sink   in_ch,
    imuca_stream_if.sink   cfg_ch,
    imuca_stream_if.source out_ch
);
    logic        q_valid, q_take;
    sample_t     q_data;
    logic [15:0] weight_reg;
    angles_t     res;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_reg <= 16'd64225;
        else if (cfg_ch.valid)
            weight_reg <= cfg_ch.data;
    end

    imuca_front u_front (
        .clk, .rst_n, .in_ch, .q_valid, .q_data, .q_take
    );

    imuca_exec #(.CORDIC_STEPS(CORDIC_STEPS)) u_exec (
        .clk, .rst_n, .q_valid, .q_data, .q_take,
        .alpha(weight_reg),
        .res_valid(out_ch.valid), .res_data(res), .res_ready(out_ch.ready)
    );

    assign out_ch.data = res;
endmodule

FILE: hdl/imuca_front.sv
module imuca_front
    import imuca_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    imuca_stream_if.sink in_ch,
    output logic    q_valid,
    output sample_t q_data,
    input  logic    q_take
);
    // two-entry queue between the intake and the execution sequencer
    sample_t    mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign pop = q_take && q_valid;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_ch.data;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push)
        else $error("push into full queue");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not grow");
endmodule

FILE: hdl/imuca_exec.sv
module imuca_exec
    import imuca_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  sample_t     q_data,
    output logic        q_take,
    input  logic [15:0] alpha,
    output logic        res_valid,
    output angles_t     res_data,
    input  logic        res_ready
);
    localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    exec_state_t state_reg, state_next;
    sample_t     smp_reg;
    logic [5:0]  cnt_reg;
    logic [33:0] mag_reg;
    logic [61:0] rem_reg;
    logic [30:0] root_reg;
    logic signed [XW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic signed [17:0] tilt_roll_reg, tilt_pitch_reg;
    logic signed [17:0] roll_reg, pitch_reg;
    logic signed [36:0] prod_r_reg, prod_p_reg;
    logic [15:0] qr_reg, qp_reg;
    logic [28:0] mr_reg, mp_reg;
    logic signed [34:0] br_g_reg, br_a_reg, bp_g_reg, bp_a_reg;
    logic        busy_out_reg;
    angles_t     out_reg;

    logic [4:0] it;
    logic signed [XW-1:0] shx, shy;
    logic signed [ZW-1:0] rz;
    logic [16:0] beta;

    assign it = cnt_reg[4:0];
    assign shx = cx_reg >>> it;
    assign shy = cy_reg >>> it;
    assign beta = 17'd65536 - {1'b0, alpha};
    assign rz = cz_reg + 32'sd128;

    assign q_take = (state_reg == ST_IDLE);
    assign res_valid = busy_out_reg;
    assign res_data = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_MAG;
            ST_MAG: state_next = ST_SQRT;
            ST_SQRT: if (cnt_reg == 6'd30) state_next = ST_RINIT;
            ST_RINIT: state_next = ST_RITER;
            ST_RITER: if (cnt_reg == 6'(NSTEPS)) state_next = ST_PINIT;
            ST_PINIT: state_next = ST_PITER;
            ST_PITER: if (cnt_reg == 6'(NSTEPS)) state_next = ST_GYRO_MUL;
            ST_GYRO_MUL: state_next = ST_GYRO_DIV;
            ST_GYRO_DIV: if (cnt_reg == 6'd1) state_next = ST_GYRO_ADD;
            ST_GYRO_ADD: state_next = ST_BLEND_MUL;
            ST_BLEND_MUL: state_next = ST_BLEND_ADD;
            ST_BLEND_ADD: state_next = ST_OUT;
            ST_OUT: if (!busy_out_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            roll_reg <= '0;
            pitch_reg <= '0;
            busy_out_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (busy_out_reg && res_ready)
                busy_out_reg <= 1'b0;
            unique case (state_reg)
                ST_SQRT, ST_RITER, ST_PITER, ST_GYRO_DIV:
                    cnt_reg <= (state_next == state_reg) ? cnt_reg + 6'd1 : 6'd0;
                default: cnt_reg <= '0;
            endcase
            if (state_reg == ST_GYRO_ADD)
            begin
                roll_reg <= clamp_angle(48'(roll_reg) +
                    (prod_r_reg < 0 ? -48'(qr_reg) : 48'(qr_reg)));
                pitch_reg <= clamp_angle(48'(pitch_reg) +
                    (prod_p_reg < 0 ? -48'(qp_reg) : 48'(qp_reg)));
            end
            if (state_reg == ST_BLEND_ADD)
            begin
                roll_reg <= clamp_angle(48'((36'(br_g_reg) + 36'(br_a_reg) + 36'sd32768) >>> 16));
                pitch_reg <= clamp_angle(48'((36'(bp_g_reg) + 36'(bp_a_reg) + 36'sd32768) >>> 16));
            end
            if (state_reg == ST_OUT && !busy_out_reg)
                busy_out_reg <= 1'b1;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (q_valid) smp_reg <= q_data;
            ST_MAG:
            begin
                mag_reg <= 34'(32'($signed(smp_reg.accel_y) * $signed(smp_reg.accel_y)))
                         + 34'(32'($signed(smp_reg.accel_z) * $signed(smp_reg.accel_z)));
                root_reg <= '0;
            end
            ST_SQRT:
            begin
                // one result bit a cycle, two radicand bits enter each step
                if (cnt_reg == 6'd0)
                begin
                    rem_reg <= 62'({mag_reg[33:32]});
                    root_reg <= '0;
                    if (mag_reg[33:32] >= 2'd1)
                    begin
                        rem_reg <= 62'(mag_reg[33:32] - 2'd1);
                        root_reg <= 31'd1;
                    end
                end
                else
                begin
                    logic [63:0] r2;
                    logic [63:0] t2;
                    r2 = {rem_reg, (cnt_reg <= 6'd16) ?
                        mag_reg[6'd33 - 6'd2*cnt_reg -: 2] : 2'b00};
                    t2 = {31'd0, root_reg, 2'b01};
                    if (r2 >= t2)
                    begin
                        rem_reg <= 62'(r2 - t2);
                        root_reg <= {root_reg[29:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= r2[61:0];
                        root_reg <= {root_reg[29:0], 1'b0};
                    end
                end
            end
            ST_RINIT, ST_PINIT:
            begin
                logic signed [XW-1:0] x0, y0;
                x0 = (state_reg == ST_RINIT) ? XW'($signed(smp_reg.accel_z)) <<< 14
                                             : XW'(root_reg);
                y0 = (state_reg == ST_RINIT) ? XW'($signed(smp_reg.accel_y)) <<< 14
                                             : -(XW'($signed(smp_reg.accel_x)) <<< 14);
                if (x0 < 0)
                begin
                    cx_reg <= -x0;
                    cy_reg <= -y0;
                    cz_reg <= (y0 >= 0) ? 32'sd11796480 : -32'sd11796480;
                end
                else
                begin
                    cx_reg <= x0;
                    cy_reg <= y0;
                    cz_reg <= '0;
                end
                if (state_reg == ST_PINIT)
                    tilt_roll_reg <= (cx_reg == 0 && cy_reg == 0) ? 18'sd0 : 18'(rz >>> 8);
            end
            ST_RITER, ST_PITER:
            begin
                if (cnt_reg != 6'(NSTEPS))
                begin
                    if (cy_reg >= 0)
                    begin
                        cx_reg <= cx_reg + shy;
                        cy_reg <= cy_reg - shx;
                        cz_reg <= cz_reg + atan_entry(it);
                    end
                    else
                    begin
                        cx_reg <= cx_reg - shy;
                        cy_reg <= cy_reg + shx;
                        cz_reg <= cz_reg - atan_entry(it);
                    end
                end
                if (state_reg == ST_PITER && cnt_reg == 6'(NSTEPS))
                    tilt_pitch_reg <= (cx_reg == 0 && cy_reg == 0) ? 18'sd0 : 18'(rz >>> 8);
            end
            ST_GYRO_MUL:
            begin
                prod_r_reg <= 37'($signed(smp_reg.rate_x) * $signed({1'b0, smp_reg.elapsed_us}))
                              <<< 4;
                prod_p_reg <= 37'($signed(smp_reg.rate_y) * $signed({1'b0, smp_reg.elapsed_us}))
                              <<< 4;
            end
            ST_GYRO_DIV:
            begin
                // (|p| + 500000) / 1e6: drop the 2^6 factor, then multiply by 2^43 / 15625
                logic [36:0] ar, ap;
                logic [58:0] pr, pp;
                ar = 37'(prod_r_reg < 0 ? -prod_r_reg : prod_r_reg) + 37'd500000;
                ap = 37'(prod_p_reg < 0 ? -prod_p_reg : prod_p_reg) + 37'd500000;
                pr = 59'(mr_reg) * 59'(GYRO_RECIP);
                pp = 59'(mp_reg) * 59'(GYRO_RECIP);
                if (cnt_reg == 6'd0)
                begin
                    mr_reg <= ar[34:6];
                    mp_reg <= ap[34:6];
                end
                else
                begin
                    qr_reg <= pr[58:43];
                    qp_reg <= pp[58:43];
                end
            end
            ST_BLEND_MUL:
            begin
                br_g_reg <= 35'($signed({1'b0, alpha}) * roll_reg);
                bp_g_reg <= 35'($signed({1'b0, alpha}) * pitch_reg);
                br_a_reg <= 35'($signed({1'b0, beta}) * tilt_roll_reg);
                bp_a_reg <= 35'($signed({1'b0, beta}) * tilt_pitch_reg);
            end
            ST_OUT:
                if (!busy_out_reg)
                begin
                    out_reg.roll_angle <= roll_reg;
                    out_reg.pitch_angle <= pitch_reg;
                    out_reg.z_rate <= smp_reg.rate_z;
                end
            default: ;
        endcase
    end

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        roll_reg <= 18'sd92160 && roll_reg >= -18'sd92160)
        else $error("roll estimate out of range");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> state_reg == ST_IDLE)
        else $error("queue read outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_reg))
        else $error("result dropped while stalled");
endmodule

FILE: tb/tb_imu_complementary_attitude.sv
module tb_imu_complementary_attitude;
    import imuca_pkg::*;

    localparam int STEPS      = 16;
    localparam int LATENCY    = 150;
    localparam int IDLE_LIMIT = 3000;

    logic clk = 1'b0;
    logic rst_n;

    imuca_stream_if #(.W($bits(sample_t)))   in_if ();
    imuca_stream_if #(.W(16))                cfg_if ();
    imuca_stream_if #(.W($bits(angles_t)))   out_if ();

    imu_complementary_attitude #(.CORDIC_STEPS(STEPS)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .cfg_ch (cfg_if),
        .out_ch (out_if)
    );

    // predictor state
    longint    roll_est;
    longint    pitch_est;
    bit [15:0] alpha;

    angles_t   attitude_q[$];
    int        errors;
    int        samples_sent;
    int        results_seen;
    int        weights_written;
    int        idle_cycles;
    bit        gaps_on;
    int        stall_mode;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        begin
            root = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= root + b)
                begin
                    n = n - (root + b);
                    root = (root >> 1) + b;
                end
                else
                    root = root >> 1;
                b = b >> 2;
            end
            return root;
        end
    endfunction

    function automatic longint atan_deg(input longint y, input longint x);
        longint z;
        longint nx;
        longint ny;
        longint step;
        begin
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            // left half plane: flip the vector and start from +-180 deg
            if (x < 0)
            begin
                z = (y >= 0) ? 180 * 65536 : -180 * 65536;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++)
            begin
                step = atan_entry(i[4:0]);
                if (y >= 0)
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z  = z + step;
                end
                else
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z  = z - step;
                end
                x = nx;
                y = ny;
            end
            return (z + 128) >>> 8;
        end
    endfunction

    function automatic longint limit_angle(input longint v);
        begin
            if (v > ANGLE_LIMIT)
                return ANGLE_LIMIT;
            if (v < -ANGLE_LIMIT)
                return -ANGLE_LIMIT;
            return v;
        end
    endfunction

    function automatic longint rate_step(input longint rate, input longint dt);
        longint p;
        longint m;
        longint q;
        begin
            p = rate * dt * 16;
            m = (p < 0) ? -p : p;
            q = (m + 500000) / 1000000;
            return (p < 0) ? -q : q;
        end
    endfunction

    function automatic longint mix(input longint gyro, input longint acc);
        longint a;
        begin
            a = alpha;
            return limit_angle((a * gyro + (65536 - a) * acc + 32768) >>> 16);
        end
    endfunction

    function automatic angles_t predict_attitude(input sample_t s);
        longint    ax;
        longint    ay;
        longint    az;
        longint    horiz;
        longint    tilt_roll;
        longint    tilt_pitch;
        angles_t   r;
        begin
            ax = s.accel_x;
            ay = s.accel_y;
            az = s.accel_z;
            horiz = int_sqrt(longint'(ay * ay + az * az) << 28);
            tilt_roll  = atan_deg(ay * 16384, az * 16384);
            tilt_pitch = atan_deg(-ax * 16384, horiz);
            roll_est  = limit_angle(roll_est + rate_step(s.rate_x, s.elapsed_us));
            pitch_est = limit_angle(pitch_est + rate_step(s.rate_y, s.elapsed_us));
            roll_est  = mix(roll_est, tilt_roll);
            pitch_est = mix(pitch_est, tilt_pitch);
            r.roll_angle  = roll_est[17:0];
            r.pitch_angle = pitch_est[17:0];
            r.z_rate      = s.rate_z;
            return r;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (!gaps_on || r < 65)
                return 0;
            if (r < 95)
                return $urandom_range(1, 4);
            return $urandom_range(20, 80);
        end
    endfunction

    task automatic send_sample(input sample_t s);
        int n;
        begin
            n = pick_gap();
            if (n > 0)
            begin
                in_if.valid <= 1'b0;
                repeat (n) @(posedge clk);
            end
            in_if.valid <= 1'b1;
            in_if.data  <= s;
            do
                @(posedge clk);
            while (!in_if.ready);
            attitude_q.push_back(predict_attitude(s));
            samples_sent++;
        end
    endtask

    task automatic drain();
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
            while (attitude_q.size() != 0)
                @(posedge clk);
            repeat (LATENCY) @(posedge clk);
        end
    endtask

    task automatic write_weight(input bit [15:0] w);
        begin
            drain();
            cfg_if.valid <= 1'b1;
            cfg_if.data  <= w;
            do
                @(posedge clk);
            while (!cfg_if.ready);
            cfg_if.valid <= 1'b0;
            alpha = w;
            weights_written++;
        end
    endtask

    function automatic sample_t make_sample(input int ax, input int ay, input int az,
                                            input int rx, input int ry, input int rz,
                                            input int dt);
        sample_t s;
        begin
            s.accel_x = ax[15:0];
            s.accel_y = ay[15:0];
            s.accel_z = az[15:0];
            s.rate_x  = rx[15:0];
            s.rate_y  = ry[15:0];
            s.rate_z  = rz[15:0];
            s.elapsed_us = dt[15:0];
            return s;
        end
    endfunction

    function automatic sample_t random_sample();
        sample_t      s;
        logic [127:0] raw;
        begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            s = raw[111:0];
            // mostly a gentle motion profile, otherwise raw noise
            if ($urandom_range(0, 3) != 0)
            begin
                s.rate_x = 16'($signed($urandom_range(0, 4000)) - 2000);
                s.rate_y = 16'($signed($urandom_range(0, 4000)) - 2000);
                s.elapsed_us = 16'($urandom_range(0, 5000));
            end
            return s;
        end
    endfunction

    // results checked against the oldest prediction
    always @(posedge clk)
    begin
        angles_t got;
        angles_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got = out_if.data;
            results_seen++;
            if (attitude_q.size() == 0)
            begin
                $display("%0t unexpected word %h", $time, got);
                errors++;
            end
            else
            begin
                want = attitude_q.pop_front();
                if (got.roll_angle !== want.roll_angle)
                begin
                    $display("%0t roll: expected %0d actual %0d",
                             $time, want.roll_angle, got.roll_angle);
                    errors++;
                end
                if (got.pitch_angle !== want.pitch_angle)
                begin
                    $display("%0t pitch: expected %0d actual %0d",
                             $time, want.pitch_angle, got.pitch_angle);
                    errors++;
                end
                if (got.z_rate !== want.z_rate)
                begin
                    $display("%0t yaw: expected %0d actual %0d",
                             $time, want.z_rate, got.z_rate);
                    errors++;
                end
            end
        end
    end

    // output back-pressure
    always @(posedge clk)
    begin
        int r;
        r = $urandom_range(0, 99);
        if (stall_mode == 0)
            out_if.ready <= 1'b1;
        else if (r < 3)
            out_if.ready <= 1'b0;
        else if (r < 30)
            out_if.ready <= ($urandom_range(0, 1) == 1);
        else
            out_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[imu_complementary_attitude] ERROR");
            $finish;
        end
    end

    task automatic test_extremes();
        begin
            send_sample(make_sample(0, 0, 0, 0, 0, 0, 0));
            send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767, 65535));
            send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
            send_sample(make_sample(0, 100, -16384, 0, 0, 1, 1000));
            send_sample(make_sample(0, -100, -16384, 0, 0, -1, 1000));
            send_sample(make_sample(0, 0, -16384, 100, -100, 5, 0));
            send_sample(make_sample(16384, 0, 0, 0, 0, 0, 100));
            send_sample(make_sample(-16384, 0, 0, 0, 0, 0, 100));
            send_sample(make_sample(0, 16384, 0, 0, 0, 0, 100));
            send_sample(make_sample(0, 0, 0, 32767, 32767, 0, 65535));
            send_sample(make_sample(0, 0, 0, 32767, 32767, 0, 65535));
            send_sample(make_sample(0, 0, 0, -32768, -32768, 0, 65535));
            send_sample(make_sample(100, 200, 16000, 3, -3, 0, 31250));
            send_sample(make_sample(100, 200, 16000, 3, -3, 0, 31249));
        end
    endtask

    task automatic test_weights();
        begin
            write_weight(16'd0);
            repeat (4) send_sample(random_sample());
            write_weight(16'hffff);
            repeat (4) send_sample(random_sample());
            send_sample(make_sample(0, 0, 0, 32767, -32768, 0, 65535));
            write_weight(16'd32768);
            repeat (4) send_sample(random_sample());
        end
    endtask

    task automatic test_random();
        begin
            for (int k = 0; k < 425; k++)
            begin
                if (k % 90 == 0)
                begin
                    gaps_on = ($urandom_range(0, 3) != 0);
                    stall_mode = $urandom_range(0, 2);
                end
                if (k % 150 == 149)
                    write_weight(16'($urandom));
                send_sample(random_sample());
            end
        end
    endtask

    initial
    begin
        errors = 0;
        samples_sent = 0;
        results_seen = 0;
        weights_written = 0;
        idle_cycles = 0;
        gaps_on = 1'b1;
        stall_mode = 1;
        roll_est = 0;
        pitch_est = 0;
        alpha = 16'd64225;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_weights();
        write_weight(16'd64225);
        test_random();
        drain();
        $display("sent %0d samples, checked %0d results, %0d weight writes",
                 samples_sent, results_seen, weights_written);
        $display("covered zero vectors, left half plane, gyro saturation and weight extremes");
        if (errors == 0 && attitude_q.size() == 0)
            $display("[imu_complementary_attitude] OK");
        else
            $display("[imu_complementary_attitude] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hdl/imuca_pkg.sv
hdl/imuca_stream_if.sv
hdl/imuca_front.sv
hdl/imuca_exec.sv
hdl/imu_complementary_attitude.sv
tb/tb_imu_complementary_attitude.sv
